/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

/* hw/rtl/cvtp_pkg.sv */
package cvtp_pkg;

   localparam int LEN_W      = 6;
   localparam int CMDQ_DEPTH = 4;

   typedef enum logic [2:0] {
      KIND_NAME  = 3'd0,
      KIND_VALUE = 3'd1,
      KIND_PAIR  = 3'd2,
      KIND_END   = 3'd3,
      KIND_ERR   = 3'd4,
      KIND_HDR   = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      OP_EMIT  = 2'd0,
      OP_STORE = 2'd1,
      OP_NAME  = 2'd2,
      OP_ABORT = 2'd3
   } op_type;

   // len doubles as the store index for OP_STORE
   typedef struct packed {
      op_type             op;
      kind_type           kind;
      logic [7:0]         chr;
      logic [LEN_W-1:0]   len;
      logic               esc;
      logic               pair;
   } cmd_type;

endpackage

/* hw/rtl/cvtp_front.sv */
`include "assert_macros.svh"

module cvtp_front
   import cvtp_pkg::*;
#(
   parameter int NAME_MAX = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_text_byte,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_DASH   = 8'h2d;
   localparam logic [7:0] CH_EQ     = 8'h3d;
   localparam logic [7:0] CH_BSLASH = 8'h5c;

   localparam int KW_COUNT = 4;
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd7, 4'd7, 4'd5, 4'd8};
   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{8'h74, 8'h79, 8'h70, 8'h65, 8'h73, 8'h65, 8'h74, 8'h00},   // typeset
      '{8'h69, 8'h6e, 8'h74, 8'h65, 8'h67, 8'h65, 8'h72, 8'h00},   // integer
      '{8'h66, 8'h6c, 8'h6f, 8'h61, 8'h74, 8'h00, 8'h00, 8'h00},   // float
      '{8'h63, 8'h6f, 8'h6d, 8'h70, 8'h6f, 8'h75, 8'h6e, 8'h64}    // compound
   };

   typedef enum logic [2:0] {
      PH_HDR, PH_PAIR, PH_NAME, PH_TSKIP, PH_TOPT, PH_VALUE, PH_DONE, PH_ERR
   } phase_type;

   typedef enum logic [1:0] {
      Q_NONE, Q_SINGLE, Q_DOUBLE
   } quote_type;

   function automatic logic is_ws(logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_alnum(logic [7:0] c);
      return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
   endfunction

   phase_type              phase_ff, phase_in;
   quote_type              quote_ff, quote_in;
   logic                   comment_ff, comment_in;
   logic                   esc_ff, esc_in;
   logic [LEN_W-1:0]       name_len_ff, name_len_in;
   logic [KW_COUNT-1:0]    kw_ff, kw_in;

   logic                   accept;
   logic                   do_start;
   logic                   do_fail;
   logic                   is_kw;
   logic [7:0]             c;

   assign accept = req_push && !q_full;
   assign c      = req_text_byte;

   always_comb begin
      is_kw = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (kw_ff[k] && name_len_ff == LEN_W'(KW_LEN[k])) is_kw = 1'b1;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      quote_in    = quote_ff;
      comment_in  = comment_ff;
      esc_in      = esc_ff;
      name_len_in = name_len_ff;
      kw_in       = kw_ff;
      do_start    = 1'b0;
      do_fail     = 1'b0;
      q_push      = 1'b0;
      q_cmd.op    = OP_EMIT;
      q_cmd.kind  = KIND_ERR;
      q_cmd.chr   = 8'h00;
      q_cmd.len   = '0;
      q_cmd.esc   = 1'b0;
      q_cmd.pair  = 1'b0;

      if (accept) begin
         if (c == CH_NUL) begin
            unique case (phase_ff) inside
               PH_HDR, PH_DONE, PH_ERR: begin
               end
               PH_VALUE: begin
                  q_push     = 1'b1;
                  q_cmd.op   = OP_ABORT;
                  q_cmd.esc  = esc_ff;
                  q_cmd.pair = (quote_ff == Q_NONE);
               end
               default: begin
                  q_push = 1'b1;
               end
            endcase
            phase_in    = PH_HDR;
            comment_in  = 1'b0;
            quote_in    = Q_NONE;
            esc_in      = 1'b0;
            name_len_in = '0;
         end else begin
            unique case (phase_ff) inside
               PH_HDR, PH_PAIR: begin
                  if (comment_ff) begin
                     if (c == CH_LF) comment_in = 1'b0;
                  end else if (is_ws(c)) begin
                  end else if (c == CH_HASH) begin
                     comment_in = 1'b1;
                  end else if (phase_ff == PH_HDR) begin
                     if (c == CH_LPAREN) begin
                        q_push     = 1'b1;
                        q_cmd.kind = KIND_HDR;
                        phase_in   = PH_PAIR;
                     end else begin
                        do_fail = 1'b1;
                     end
                  end else if (c == CH_RPAREN) begin
                     q_push     = 1'b1;
                     q_cmd.kind = KIND_END;
                     phase_in   = PH_DONE;
                  end else begin
                     do_start = 1'b1;
                  end
               end
               PH_NAME: begin
                  if (is_alnum(c)) begin
                     if (name_len_ff >= LEN_W'(NAME_MAX)) begin
                        do_fail = 1'b1;
                     end else begin
                        q_push      = 1'b1;
                        q_cmd.op    = OP_STORE;
                        q_cmd.chr   = c;
                        q_cmd.len   = name_len_ff;
                        name_len_in = name_len_ff + LEN_W'(1);
                        for (int k = 0; k < KW_COUNT; k++) begin
                           kw_in[k] = kw_ff[k] && (name_len_ff < LEN_W'(KW_LEN[k])) &&
                                      (c == KW_TEXT[k][name_len_ff[2:0]]);
                        end
                     end
                  end else if (c == CH_EQ) begin
                     q_push    = 1'b1;
                     q_cmd.op  = OP_NAME;
                     q_cmd.len = name_len_ff;
                     phase_in  = PH_VALUE;
                     quote_in  = Q_NONE;
                     esc_in    = 1'b0;
                  end else if (is_ws(c) && is_kw) begin
                     phase_in = PH_TSKIP;
                  end else begin
                     do_fail = 1'b1;
                  end
               end
               PH_TSKIP: begin
                  if (is_ws(c)) begin
                  end else if (c == CH_DASH) begin
                     phase_in = PH_TOPT;
                  end else begin
                     do_start = 1'b1;
                  end
               end
               PH_TOPT: begin
                  if (is_alnum(c) || c == CH_DASH) begin
                  end else if (is_ws(c)) begin
                     phase_in = PH_TSKIP;
                  end else begin
                     do_fail = 1'b1;
                  end
               end
               PH_VALUE: begin
                  if (esc_ff) begin
                     esc_in     = 1'b0;
                     q_push     = 1'b1;
                     q_cmd.kind = KIND_VALUE;
                     q_cmd.chr  = c;
                  end else if (c == CH_BSLASH) begin
                     esc_in = 1'b1;
                  end else if (quote_ff == Q_SINGLE) begin
                     if (c == CH_SQUOTE) begin
                        quote_in = Q_NONE;
                     end else begin
                        q_push     = 1'b1;
                        q_cmd.kind = KIND_VALUE;
                        q_cmd.chr  = c;
                     end
                  end else if (quote_ff == Q_DOUBLE) begin
                     if (c == CH_DQUOTE) begin
                        quote_in = Q_NONE;
                     end else begin
                        q_push     = 1'b1;
                        q_cmd.kind = KIND_VALUE;
                        q_cmd.chr  = c;
                     end
                  end else if (is_ws(c)) begin
                     q_push      = 1'b1;
                     q_cmd.kind  = KIND_PAIR;
                     phase_in    = PH_PAIR;
                     comment_in  = 1'b0;
                     name_len_in = '0;
                  end else if (c == CH_DQUOTE) begin
                     quote_in = Q_DOUBLE;
                  end else if (c == CH_SQUOTE) begin
                     quote_in = Q_SINGLE;
                  end else begin
                     q_push     = 1'b1;
                     q_cmd.kind = KIND_VALUE;
                     q_cmd.chr  = c;
                  end
               end
               PH_DONE, PH_ERR: begin
               end
            endcase

            if (do_start) begin
               if (is_alpha(c)) begin
                  q_push      = 1'b1;
                  q_cmd.op    = OP_STORE;
                  q_cmd.chr   = c;
                  q_cmd.len   = '0;
                  name_len_in = LEN_W'(1);
                  phase_in    = PH_NAME;
                  for (int k = 0; k < KW_COUNT; k++) begin
                     kw_in[k] = (c == KW_TEXT[k][0]);
                  end
               end else begin
                  do_fail = 1'b1;
               end
            end

            if (do_fail) begin
               q_push     = 1'b1;
               q_cmd.op   = OP_EMIT;
               q_cmd.kind = KIND_ERR;
               q_cmd.chr  = 8'h00;
               phase_in   = PH_ERR;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR;
         quote_ff    <= Q_NONE;
         comment_ff  <= 1'b0;
         esc_ff      <= 1'b0;
         name_len_ff <= '0;
         kw_ff       <= '0;
      end else begin
         phase_ff    <= phase_in;
         quote_ff    <= quote_in;
         comment_ff  <= comment_in;
         esc_ff      <= esc_in;
         name_len_ff <= name_len_in;
         kw_ff       <= kw_in;
      end
   end

   `ASSERT_PROP(a_len_bound, clock, reset, name_len_ff <= LEN_W'(NAME_MAX))
   `ASSERT_PROP(a_name_nonempty, clock, reset, (phase_ff == PH_NAME) |-> (name_len_ff != '0))

endmodule

/* hw/rtl/cvtp_cmd_fifo.sv */
`include "assert_macros.svh"

module cvtp_cmd_fifo
   import cvtp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type            entry_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full     = (count_ff == CNT_W'(CMDQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         case ({push, pop})
            2'b10:   count_ff <= count_ff + CNT_W'(1);
            2'b01:   count_ff <= count_ff - CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `ASSERT_NEVER(a_no_underflow, clock, reset, pop && empty)

endmodule

/* hw/rtl/cvtp_back.sv */
`include "assert_macros.svh"

module cvtp_back
   import cvtp_pkg::*;
#(
   parameter int NAME_MAX = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last_of_run
);

   localparam int ADDR_W = $clog2(NAME_MAX);

   typedef enum logic [1:0] {
      ST_IDLE, ST_NAME_FETCH, ST_NAME_PUT, ST_ABORT
   } state_type;

   state_type          state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   kind_type           out_kind_ff, out_kind_in;
   logic [7:0]         out_chr_ff, out_chr_in;
   logic               out_last_ff, out_last_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               esc_ff, esc_in;
   logic               pair_ff, pair_in;

   logic [7:0]         name_mem [NAME_MAX];
   logic [7:0]         rd_data_ff;
   logic               mem_we;
   logic               out_free;
   logic               name_last;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign name_last = (pos_ff == len_ff - LEN_W'(1));

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_kind_in  = out_kind_ff;
      out_chr_in   = out_chr_ff;
      out_last_in  = out_last_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      esc_in       = esc_ff;
      pair_in      = pair_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               unique case (q_cmd.op)
                  OP_STORE: begin
                     q_pop  = 1'b1;
                     mem_we = 1'b1;
                  end
                  OP_EMIT: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        out_valid_in = 1'b1;
                        out_kind_in  = q_cmd.kind;
                        out_chr_in   = q_cmd.chr;
                        out_last_in  = 1'b1;
                     end
                  end
                  OP_NAME: begin
                     q_pop    = 1'b1;
                     len_in   = q_cmd.len;
                     pos_in   = '0;
                     state_in = ST_NAME_FETCH;
                  end
                  OP_ABORT: begin
                     q_pop    = 1'b1;
                     esc_in   = q_cmd.esc;
                     pair_in  = q_cmd.pair;
                     state_in = ST_ABORT;
                  end
               endcase
            end
         end
         ST_NAME_FETCH: begin
            state_in = ST_NAME_PUT;
         end
         ST_NAME_PUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = KIND_NAME;
               out_chr_in   = rd_data_ff;
               out_last_in  = name_last;
               if (name_last) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in   = pos_ff + LEN_W'(1);
                  state_in = ST_NAME_FETCH;
               end
            end
         end
         ST_ABORT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (esc_ff) begin
                  out_kind_in = KIND_VALUE;
                  out_chr_in  = 8'h5c;
                  out_last_in = 1'b0;
                  esc_in      = 1'b0;
               end else if (pair_ff) begin
                  out_kind_in = KIND_PAIR;
                  out_chr_in  = 8'h00;
                  out_last_in = 1'b0;
                  pair_in     = 1'b0;
               end else begin
                  out_kind_in = KIND_ERR;
                  out_chr_in  = 8'h00;
                  out_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      out_kind_ff <= out_kind_in;
      out_chr_ff  <= out_chr_in;
      out_last_ff <= out_last_in;
      pos_ff      <= pos_in;
      len_ff      <= len_in;
      esc_ff      <= esc_in;
      pair_ff     <= pair_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) name_mem[q_cmd.len[ADDR_W-1:0]] <= q_cmd.chr;
      rd_data_ff <= name_mem[pos_ff[ADDR_W-1:0]];
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_char_out    = out_chr_ff;
   assign rsp_last_of_run = out_last_ff;

   `ASSERT_PROP(a_name_pos, clock, reset, (state_ff == ST_NAME_PUT) |-> (pos_ff < len_ff))

endmodule

/* hw/rtl/compound_variable_text_parser_core.sv */
// Channel   Handshake        Payload
// req_      push / full      text_byte[7:0]
// rsp_      pop / empty      kind[2:0], char_out[7:0], last_of_run
//
// One text byte is taken per cycle while the 4-entry command queue has room.
// A byte yields at most one result, except '=' and a zero byte in a value: the
// buffered name leaves the back end one character at a time (name RAM read),
// and a zero byte gives up to three results, one per cycle while popped.
// Reset is synchronous; the name RAM is not cleared. full follows the queue,
// so a stalled result side backs up into req_full once four commands wait.
module compound_variable_text_parser_core
   import cvtp_pkg::*;
#(
   parameter int NAME_MAX = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_text_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last_of_run
);

   logic    q_push, q_pop, q_full, q_empty;
   cmd_type q_wr_cmd, q_rd_cmd;

   assign req_full = q_full;

   cvtp_front #(
      .NAME_MAX(NAME_MAX)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_text_byte (req_text_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_wr_cmd)
   );

   cvtp_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_cmd),
      .empty     (q_empty)
   );

   cvtp_back #(
      .NAME_MAX(NAME_MAX)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_cmd           (q_rd_cmd),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_char_out    (rsp_char_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

/* test/tb_compound_variable_text_parser_core.sv */
module tb_compound_variable_text_parser_core
   import cvtp_pkg::*;
();

   localparam int NAME_LIMIT  = 32;
   localparam int ITEM_TARGET = 370;
   localparam int DIR_N       = 26;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN       = 60;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   localparam logic [63:0] KW_TYPESET  = "typeset";
   localparam logic [63:0] KW_INTEGER  = "integer";
   localparam logic [63:0] KW_FLOAT    = "float";
   localparam logic [63:0] KW_COMPOUND = "compound";

   typedef enum logic [2:0] {
      P_HDR, P_PAIR, P_NAME, P_TSKIP, P_TOPT, P_VALUE, P_DONE, P_ERR
   } phase_type;

   typedef enum logic [1:0] {Q_NONE, Q_SINGLE, Q_DOUBLE} quote_type;

   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] chr;
      logic       last;
   } token_type;

   typedef struct packed {
      logic [7:0] txt;
      chk_type    chk;
      kind_type   kind;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_text_byte = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_char_out;
   logic       rsp_last_of_run;

   logic       go = 1'b0;
   logic       hold_off = 1'b0;
   logic [7:0] text_q[$];
   token_type  pending_tokens[$];
   token_type  step_tokens[$];
   int         n_items;
   int         sent = 0;
   int         bad = 0;
   int         n_checked = 0;
   int         n_pairs = 0;
   int         n_errs = 0;
   int         full_cycles = 0;
   int         cycle_cnt = 0;
   bit         noisy;

   // parser state
   phase_type  ph;
   quote_type  qm;
   logic       cmt;
   logic       esc;
   logic [7:0] nbuf[0:63];
   int         nlen;

   compound_variable_text_parser_core #(.NAME_MAX(NAME_LIMIT)) uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_text_byte(req_text_byte),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_kind(rsp_kind),
      .rsp_char_out(rsp_char_out),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic dir_row_type dir_row(input int i);
      case (i)
         0:  return {CH_NUL,   CHK_NONE,  KIND_NAME};
         1:  return {8'h09,    CHK_MODEL, KIND_NAME};
         2:  return {CH_HASH,  CHK_MODEL, KIND_NAME};
         3:  return {8'hFF,    CHK_MODEL, KIND_NAME};
         4:  return {CH_LF,    CHK_MODEL, KIND_NAME};
         5:  return {CH_LPAREN, CHK_ONE,  KIND_HDR};
         6:  return {8'h7A,    CHK_MODEL, KIND_NAME};
         7:  return {8'h5A,    CHK_MODEL, KIND_NAME};
         8:  return {8'h39,    CHK_MODEL, KIND_NAME};
         9:  return {CH_EQ,    CHK_MODEL, KIND_NAME};
         10: return {8'h80,    CHK_MODEL, KIND_NAME};
         11: return {CH_BSLASH, CHK_MODEL, KIND_NAME};
         12: return {CH_NUL,   CHK_MODEL, KIND_NAME};
         13: return {8'hFF,    CHK_ONE,   KIND_ERR};
         14: return {CH_NUL,   CHK_NONE,  KIND_NAME};
         15: return {CH_LPAREN, CHK_ONE,  KIND_HDR};
         16: return {CH_RPAREN, CHK_ONE,  KIND_END};
         17: return {8'h78,    CHK_MODEL, KIND_NAME};
         18: return {CH_NUL,   CHK_NONE,  KIND_NAME};
         19: return {CH_LPAREN, CHK_ONE,  KIND_HDR};
         20: return {8'h31,    CHK_ONE,   KIND_ERR};
         21: return {CH_NUL,   CHK_NONE,  KIND_NAME};
         22: return {CH_LPAREN, CHK_ONE,  KIND_HDR};
         23: return {8'h61,    CHK_MODEL, KIND_NAME};
         24: return {CH_SPACE, CHK_ONE,   KIND_ERR};
         default: return {CH_NUL, CHK_NONE, KIND_NAME};
      endcase
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic logic is_keyword();
      logic [63:0] nm;
      int i;
      nm = '0;
      if (nlen > 8) return 1'b0;
      for (i = 0; i < nlen; i++) nm = {nm[55:0], nbuf[i]};
      return (nlen == 7 && (nm == KW_TYPESET || nm == KW_INTEGER)) ||
             (nlen == 5 && nm == KW_FLOAT) || (nlen == 8 && nm == KW_COMPOUND);
   endfunction

   task automatic emit(input kind_type k, input logic [7:0] ch);
      token_type t;
      t.kind = k;
      t.chr  = ch;
      t.last = 1'b0;
      step_tokens.push_back(t);
   endtask

   task automatic fail_now();
      emit(KIND_ERR, 8'h00);
      ph = P_ERR;
   endtask

   task automatic open_name(input logic [7:0] c);
      if (is_alpha(c)) begin
         nbuf[0] = c;
         nlen = 1;
         ph = P_NAME;
      end else begin
         fail_now();
      end
   endtask

   task automatic parse_reset();
      ph = P_HDR;
      qm = Q_NONE;
      cmt = 1'b0;
      esc = 1'b0;
      nlen = 0;
   endtask

   task automatic parse_byte(input logic [7:0] c);
      token_type t;
      int i;
      step_tokens.delete();
      if (c == CH_NUL) begin
         case (ph)
            P_HDR, P_DONE, P_ERR: ;
            P_VALUE: begin
               if (esc) emit(KIND_VALUE, CH_BSLASH);
               if (qm == Q_NONE) emit(KIND_PAIR, 8'h00);
               emit(KIND_ERR, 8'h00);
            end
            default: emit(KIND_ERR, 8'h00);
         endcase
         parse_reset();
      end else begin
         case (ph)
            P_HDR, P_PAIR: begin
               if (cmt) begin
                  if (c == CH_LF) cmt = 1'b0;
               end else if (c == CH_HASH) begin
                  cmt = 1'b1;
               end else if (!is_space(c)) begin
                  if (ph == P_HDR) begin
                     if (c == CH_LPAREN) begin
                        emit(KIND_HDR, 8'h00);
                        ph = P_PAIR;
                     end else begin
                        fail_now();
                     end
                  end else if (c == CH_RPAREN) begin
                     emit(KIND_END, 8'h00);
                     ph = P_DONE;
                  end else begin
                     open_name(c);
                  end
               end
            end
            P_NAME: begin
               if (is_alnum(c)) begin
                  if (nlen >= NAME_LIMIT) begin
                     fail_now();
                  end else begin
                     nbuf[nlen] = c;
                     nlen++;
                  end
               end else if (c == CH_EQ) begin
                  for (i = 0; i < nlen; i++) emit(KIND_NAME, nbuf[i]);
                  ph = P_VALUE;
                  qm = Q_NONE;
                  esc = 1'b0;
               end else if (is_space(c) && is_keyword()) begin
                  ph = P_TSKIP;
               end else begin
                  fail_now();
               end
            end
            P_TSKIP: begin
               if (c == CH_DASH) ph = P_TOPT;
               else if (!is_space(c)) open_name(c);
            end
            P_TOPT: begin
               if (is_space(c)) ph = P_TSKIP;
               else if (!is_alnum(c) && c != CH_DASH) fail_now();
            end
            P_VALUE: begin
               if (esc) begin
                  esc = 1'b0;
                  emit(KIND_VALUE, c);
               end else if (c == CH_BSLASH) begin
                  esc = 1'b1;
               end else if (qm == Q_SINGLE) begin
                  if (c == CH_SQUOTE) qm = Q_NONE;
                  else emit(KIND_VALUE, c);
               end else if (qm == Q_DOUBLE) begin
                  if (c == CH_DQUOTE) qm = Q_NONE;
                  else emit(KIND_VALUE, c);
               end else if (is_space(c)) begin
                  emit(KIND_PAIR, 8'h00);
                  ph = P_PAIR;
                  cmt = 1'b0;
                  nlen = 0;
               end else if (c == CH_DQUOTE) begin
                  qm = Q_DOUBLE;
               end else if (c == CH_SQUOTE) begin
                  qm = Q_SINGLE;
               end else begin
                  emit(KIND_VALUE, c);
               end
            end
            default: ;
         endcase
      end
      if (step_tokens.size() > 0) begin
         t = step_tokens.pop_back();
         t.last = 1'b1;
         step_tokens.push_back(t);
      end
   endtask

   // ---- text generation ----

   task automatic put_txt(input logic [7:0] b);
      logic [7:0] junk;
      junk = 8'($urandom_range(255, 0));
      if (noisy && $urandom_range(49, 0) == 0) text_q.push_back(junk);
      else text_q.push_back(b);
   endtask

   task automatic put_word(input logic [63:0] w, input int wl);
      int i;
      for (i = wl - 1; i >= 0; i--) put_txt(w[i*8 +: 8]);
   endtask

   task automatic pick_kw(output logic [63:0] w, output int wl);
      case ($urandom_range(3, 0))
         0: begin w = KW_TYPESET;  wl = 7; end
         1: begin w = KW_INTEGER;  wl = 7; end
         2: begin w = KW_FLOAT;    wl = 5; end
         default: begin w = KW_COMPOUND; wl = 8; end
      endcase
   endtask

   function automatic logic [7:0] rand_space();
      int r;
      r = $urandom_range(5, 0);
      return (r == 5) ? CH_SPACE : 8'h09 + r[7:0];
   endfunction

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(51, 0);
      return (r < 26) ? 8'h61 + r[7:0] : 8'h41 + r[7:0] - 8'd26;
   endfunction

   function automatic logic [7:0] rand_alnum();
      int r;
      r = $urandom_range(61, 0);
      return (r < 52) ? rand_letter() : 8'h30 + r[7:0] - 8'd52;
   endfunction

   function automatic logic [7:0] rand_plain();
      logic [7:0] b;
      do b = 8'($urandom_range(255, 1));
      while (is_space(b) || b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BSLASH);
      return b;
   endfunction

   task automatic put_quoted(input logic [7:0] q, input bit closed);
      logic [7:0] b;
      put_txt(q);
      repeat ($urandom_range(5, 0)) begin
         do b = 8'($urandom_range(255, 1));
         while (b == q || b == CH_BSLASH);
         put_txt(b);
      end
      if (closed) put_txt(q);
   endtask

   task automatic put_gap();
      logic [7:0] b;
      repeat ($urandom_range(3, 0)) begin
         if ($urandom_range(3, 0) == 0) begin
            put_txt(CH_HASH);
            repeat ($urandom_range(6, 0)) begin
               do b = 8'($urandom_range(255, 1));
               while (b == CH_LF);
               put_txt(b);
            end
            put_txt(CH_LF);
         end else begin
            put_txt(rand_space());
         end
      end
   endtask

   task automatic put_pair(input bit want_kw, input bit want_long, input bit closed);
      logic [63:0] w;
      int wl, nl, r;
      put_gap();
      if (want_kw || $urandom_range(3, 0) == 0) begin
         pick_kw(w, wl);
         put_word(w, wl);
         put_txt(rand_space());
         repeat (want_kw ? 2 : $urandom_range(2, 0)) begin
            put_txt(CH_DASH);
            repeat ($urandom_range(3, 0)) put_txt(rand_alnum());
            if ($urandom_range(2, 0) == 0) put_txt(CH_DASH);
            put_txt(rand_space());
         end
      end
      r = $urandom_range(15, 0);
      if (want_long) nl = NAME_LIMIT + 1;
      else if (r == 0) nl = 0;
      else if (r == 1) nl = $urandom_range(NAME_LIMIT + 2, NAME_LIMIT - 4);
      else nl = $urandom_range(8, 1);
      if (nl == 0) begin
         pick_kw(w, wl);
         put_word(w, wl);
      end else begin
         put_txt(rand_letter());
         repeat (nl - 1) put_txt(rand_alnum());
      end
      put_txt(CH_EQ);
      repeat ($urandom_range(4, 0)) begin
         case ($urandom_range(5, 0))
            3: put_quoted(CH_SQUOTE, 1'b1);
            4: put_quoted(CH_DQUOTE, 1'b1);
            5: begin
               put_txt(CH_BSLASH);
               put_txt(8'($urandom_range(255, 1)));
            end
            default: put_txt(rand_plain());
         endcase
      end
      if (closed) begin
         put_txt(rand_space());
      end else begin
         case ($urandom_range(2, 0))
            0: put_txt(CH_BSLASH);
            1: put_quoted($urandom_range(1, 0) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
            default: ;
         endcase
      end
   endtask

   task automatic put_record(input bit special);
      int np, ending, p;
      noisy = !special && $urandom_range(9, 0) == 0;
      if (!special && $urandom_range(9, 0) == 0) begin
         repeat ($urandom_range(10, 1)) put_txt(8'($urandom_range(255, 1)));
         put_txt(CH_NUL);
         return;
      end
      put_gap();
      put_txt(CH_LPAREN);
      np = special ? 2 : $urandom_range(4, 1);
      ending = special ? 0 : $urandom_range(9, 0);
      for (p = 0; p < np; p++)
         put_pair(special && p == 0, special && p == np - 1, !(ending == 9 && p == np - 1));
      if (ending < 7) begin
         put_gap();
         put_txt(CH_RPAREN);
         if ($urandom_range(3, 0) == 0) put_txt(rand_plain());
      end
      put_txt(CH_NUL);
   endtask

   // ---- checking ----

   task automatic log_bad(input string why, input token_type e);
      bad++;
      if (bad <= 10)
         $display({"mismatch %0d (%s): expected kind %0d char %02h last %0b,",
                   " got kind %0d char %02h last %0b"},
                  bad, why, e.kind, e.chr, e.last, rsp_kind, rsp_char_out, rsp_last_of_run);
   endtask

   function automatic int phase_of();
      if (sent >= n_items) return 0;
      return sent * 4 / n_items;
   endfunction

   always @(posedge clock) begin : drive_req
      dir_row_type row;
      token_type t;
      logic nxt_push;
      int idle_pct, i;
      nxt_push = req_push;
      if (go) begin
         if (req_push && !req_full) begin
            parse_byte(req_text_byte);
            row = dir_row(sent);
            if (sent < DIR_N && row.chk != CHK_MODEL) begin
               if (row.chk == CHK_ONE) begin
                  t.kind = row.kind;
                  t.chr  = 8'h00;
                  t.last = 1'b1;
                  pending_tokens.push_back(t);
               end
            end else begin
               for (i = 0; i < step_tokens.size(); i++) pending_tokens.push_back(step_tokens[i]);
            end
            sent++;
         end
         if (req_push && req_full) begin
            full_cycles++;
         end else begin
            case (phase_of())
               1: idle_pct = 59;
               3: idle_pct = 30;
               default: idle_pct = 0;
            endcase
            nxt_push = sent < n_items && $urandom_range(99, 0) >= idle_pct;
         end
      end
      req_push <= nxt_push;
      if (nxt_push) req_text_byte <= text_q[sent];
   end

   always @(posedge clock) begin : take_rsp
      token_type e;
      int stall_pct;
      if (rsp_pop && !rsp_empty) begin
         n_checked++;
         if (rsp_kind == KIND_PAIR) n_pairs++;
         if (rsp_kind == KIND_ERR) n_errs++;
         if (pending_tokens.size() == 0) begin
            e = '0;
            log_bad("no transaction expected", e);
         end else begin
            e = pending_tokens.pop_front();
            if (rsp_kind !== e.kind || rsp_char_out !== e.chr || rsp_last_of_run !== e.last)
               log_bad("field", e);
         end
      end
      case (phase_of())
         2: stall_pct = 59;
         3: stall_pct = 30;
         default: stall_pct = 0;
      endcase
      rsp_pop <= go && !hold_off && $urandom_range(99, 0) >= stall_pct;
   end

   // long result-side hold-off while the sender keeps offering
   initial begin : hold_rsp
      while (sent < 40) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : watchdog
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : main
      dir_row_type row;
      int i;
      parse_reset();
      for (i = 0; i < DIR_N; i++) begin
         row = dir_row(i);
         text_q.push_back(row.txt);
      end
      put_record(1'b1);
      while (text_q.size() < ITEM_TARGET) put_record(1'b0);
      n_items = text_q.size();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      go <= 1'b1;
      while (sent < n_items) @(posedge clock);
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (pending_tokens.size() != 0) begin
         bad += pending_tokens.size();
         $display("%0d expected transactions never arrived", pending_tokens.size());
      end
      $display("Sent %0d text bytes (%0d directed); checked %0d results,",
               n_items, DIR_N, n_checked);
      $display("%0d pair ends, %0d errors; input held by full %0d cycles.",
               n_pairs, n_errs, full_cycles);
      $display("Idle mixes: none, sender 59%%, receiver 59%%, both 30%%.");
      if (bad == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
